>>> hdl/imhq_pkg.sv
package imhq_pkg;

    localparam int HeapDepthDefault   = 1024;
    localparam int HandleCountDefault = 1024;
    localparam int KeyWidthDefault    = 32;

    localparam logic [1:0] MODE_PUSH  = 2'd0;
    localparam logic [1:0] MODE_POP   = 2'd1;
    localparam logic [1:0] MODE_ERASE = 2'd2;
    localparam logic [1:0] MODE_NOP   = 2'd3;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_EMPTY  = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;
    localparam logic [1:0] ST_HANDLE = 2'd3;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_CHECK,
        S_LAST_RD,
        S_LAST_WAIT,
        S_UP_RD,
        S_UP_CMP,
        S_DN_RD,
        S_DN_CMP,
        S_FINAL,
        S_OUT
    } imhq_state_t;

endpackage

>>> hdl/imhq_slot_ram.sv
module imhq_slot_ram
    import imhq_pkg::*;
#(
    parameter int AW = 10,
    parameter int DW = 42
)
(
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic [AW-1:0] raddr_a,
    output logic [DW-1:0] rdata_a,
    input  logic [AW-1:0] raddr_b,
    output logic [DW-1:0] rdata_b
);

    logic [DW-1:0] mem [2**AW];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

>>> hdl/imhq_pos_ram.sv
module imhq_pos_ram
    import imhq_pkg::*;
#(
    parameter int HW = 10,
    parameter int SW = 10
)
(
    input  logic          clk,
    input  logic          we,
    input  logic [HW-1:0] waddr,
    input  logic [SW-1:0] wdata,
    input  logic [HW-1:0] raddr,
    output logic [SW-1:0] rdata
);

    logic [SW-1:0] mem [2**HW];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> hdl/indexed_min_heap_queue.sv
// Indexed min-heap priority queue: push, pop minimum, erase by handle.
// One transaction at a time; the next is accepted the cycle after the result register
// loads. Each heap level walked takes one read-compare step.
// Reset (rst_n low, asynchronous) empties the heap, then a clearing pass wipes every
// presence bit while s_tready stays low; slot memory needs no clearing.
module indexed_min_heap_queue
    import imhq_pkg::*;
#(
    parameter int HEAP_DEPTH   = HeapDepthDefault,
    parameter int HANDLE_COUNT = HandleCountDefault,
    parameter int KEY_WIDTH    = KeyWidthDefault
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // mode[1:0], item_handle[11:2], item_key[43:12]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata    // out_handle[9:0], out_key[41:10], status[43:42],
                                   // entry_total[54:44]
);

    localparam int AW = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1;
    localparam int HW = (HANDLE_COUNT > 1) ? $clog2(HANDLE_COUNT) : 1;
    localparam int CW = $clog2(HEAP_DEPTH + 1);
    localparam int DW = KEY_WIDTH + HW;

    imhq_state_t state_reg, state_next;

    logic [CW-1:0]        count_reg, count_next;
    logic [HW-1:0]        clr_reg, clr_next;
    logic [1:0]           mode_reg;
    logic [9:0]           hin_reg;
    logic [31:0]          kin_reg;
    // item being sifted, biased key
    logic [KEY_WIDTH-1:0] key_reg, key_next;
    logic [HW-1:0]        hnd_reg, hnd_next;
    logic [AW-1:0]        pos_reg, pos_next;
    logic                 moved_reg, moved_next;
    logic                 erase_up_reg, erase_up_next;
    logic [9:0]           rh_reg, rh_next;
    logic [31:0]          rk_reg, rk_next;
    logic [1:0]           st_reg, st_next;
    logic                 out_valid_reg;
    logic [54:0]          res_reg;

    // memory ports; position entries carry a presence bit above the slot
    logic          s_we;
    logic [AW-1:0] s_waddr, s_ra, s_rb;
    logic [DW-1:0] s_wdata, s_da, s_db;
    logic          p_we;
    logic [HW-1:0] p_waddr, p_raddr;
    logic [AW:0]   p_wdata, p_rdata;
    logic [AW-1:0] last_idx;

    imhq_slot_ram #(.AW(AW), .DW(DW)) u_slot (
        .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
        .raddr_a(s_ra), .rdata_a(s_da), .raddr_b(s_rb), .rdata_b(s_db)
    );

    imhq_pos_ram #(.HW(HW), .SW(AW + 1)) u_pos (
        .clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
        .raddr(p_raddr), .rdata(p_rdata)
    );

    function automatic logic [31:0] unbias(input logic [KEY_WIDTH-1:0] kb);
        logic [KEY_WIDTH-1:0] k;
        logic [63:0] e;
        begin
            k = kb ^ (KEY_WIDTH'(1) << (KEY_WIDTH - 1));
            e = 64'($signed(k));
            unbias = e[31:0];
        end
    endfunction

    logic                 h_ok;
    logic [KEY_WIDTH-1:0] ka, kb_;
    logic [HW-1:0]        ha, hb;
    logic [AW:0]          lchild;
    logic                 lc_in, rc_in;
    logic [AW-1:0]        parent;
    logic [63:0]          kin_ext;

    assign ka  = s_da[DW-1:HW];
    assign ha  = s_da[HW-1:0];
    assign kb_ = s_db[DW-1:HW];
    assign hb  = s_db[HW-1:0];
    assign lchild = {pos_reg, 1'b1};
    assign lc_in  = (AW+1)'(lchild) < (AW+1)'(count_reg);
    assign rc_in  = (AW+1)'(lchild + 1'b1) < (AW+1)'(count_reg);
    assign parent = (pos_reg - 1'b1) >> 1;
    assign last_idx = AW'(count_reg - 1'b1);
    assign kin_ext  = 64'($signed(kin_reg));
    assign h_ok = (32'(hin_reg) < HANDLE_COUNT);

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, res_reg};

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        clr_next      = clr_reg;
        key_next      = key_reg;
        hnd_next      = hnd_reg;
        pos_next      = pos_reg;
        moved_next    = moved_reg;
        erase_up_next = erase_up_reg;
        rh_next       = rh_reg;
        rk_next       = rk_reg;
        st_next       = st_reg;
        s_we = 1'b0; s_waddr = pos_reg; s_wdata = {key_reg, hnd_reg};
        s_ra = '0; s_rb = '0;
        p_we = 1'b0; p_waddr = hnd_reg; p_wdata = {1'b1, pos_reg};
        p_raddr = HW'(hin_reg);
        case (state_reg)
            S_CLEAR:
            begin
                // wipe one presence entry per cycle
                p_we = 1'b1; p_waddr = clr_reg; p_wdata = '0;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == HW'(HANDLE_COUNT - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                // look up the offered handle so its entry is ready in S_CHECK
                p_raddr = HW'(s_tdata[11:2]);
                if (s_tvalid)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                rh_next = '0; rk_next = '0; st_next = ST_OK;
                moved_next = 1'b0; erase_up_next = 1'b0;
                s_ra = '0;
                case (mode_reg)
                    MODE_PUSH:
                    begin
                        if (32'(count_reg) >= HEAP_DEPTH)
                        begin
                            st_next = ST_FULL; state_next = S_OUT;
                        end
                        else if (!h_ok || p_rdata[AW])
                        begin
                            st_next = ST_HANDLE; state_next = S_OUT;
                        end
                        else
                        begin
                            key_next = kin_ext[KEY_WIDTH-1:0]
                                       ^ (KEY_WIDTH'(1) << (KEY_WIDTH - 1));
                            hnd_next = HW'(hin_reg);
                            pos_next = AW'(count_reg);
                            count_next = count_reg + 1'b1;
                            state_next = S_UP_RD;
                        end
                    end
                    MODE_POP:
                    begin
                        if (count_reg == '0)
                        begin
                            st_next = ST_EMPTY; state_next = S_OUT;
                        end
                        else
                        begin
                            pos_next = '0;
                            state_next = S_LAST_RD;
                        end
                    end
                    MODE_ERASE:
                    begin
                        if (!h_ok || !p_rdata[AW])
                        begin
                            st_next = ST_HANDLE; state_next = S_OUT;
                        end
                        else
                        begin
                            p_raddr = HW'(hin_reg);
                            state_next = S_LAST_RD;
                        end
                    end
                    default:
                    begin
                        state_next = S_OUT;
                    end
                endcase
            end
            S_LAST_RD:
            begin
                // read the hole (port a) and last entry (port b)
                if (mode_reg == MODE_ERASE)
                begin
                    pos_next = p_rdata[AW-1:0];
                    s_ra = p_rdata[AW-1:0];
                end
                else
                begin
                    s_ra = '0;
                end
                s_rb = last_idx;
                state_next = S_LAST_WAIT;
            end
            S_LAST_WAIT:
            begin
                rh_next = 10'(ha);
                rk_next = unbias(ka);
                // drop the removed handle's presence
                p_we = 1'b1; p_waddr = ha; p_wdata = '0;
                count_next = count_reg - 1'b1;
                key_next = kb_; hnd_next = hb;
                if (pos_reg == last_idx)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    state_next = S_DN_RD;
                end
            end
            S_UP_RD:
            begin
                s_ra = parent;
                if (pos_reg == '0)
                begin
                    state_next = S_FINAL;
                end
                else
                begin
                    state_next = S_UP_CMP;
                end
            end
            S_UP_CMP:
            begin
                if (key_reg < ka)
                begin
                    s_we = 1'b1; s_waddr = pos_reg; s_wdata = s_da;
                    p_we = 1'b1; p_waddr = ha; p_wdata = {1'b1, pos_reg};
                    pos_next = parent;
                    moved_next = 1'b1;
                    state_next = S_UP_RD;
                end
                else
                begin
                    state_next = S_FINAL;
                end
            end
            S_DN_RD:
            begin
                s_ra = AW'(lchild);
                s_rb = AW'(lchild + 1'b1);
                if (!lc_in)
                begin
                    state_next = S_FINAL;
                end
                else
                begin
                    state_next = S_DN_CMP;
                end
            end
            S_DN_CMP:
            begin
                if (rc_in && (kb_ < ka))
                begin
                    if (kb_ < key_reg)
                    begin
                        s_we = 1'b1; s_wdata = s_db;
                        p_we = 1'b1; p_waddr = hb;
                        pos_next = AW'(lchild + 1'b1);
                        moved_next = 1'b1;
                        state_next = S_DN_RD;
                    end
                    else
                    begin
                        state_next = S_FINAL;
                    end
                end
                else if (ka < key_reg)
                begin
                    s_we = 1'b1; s_wdata = s_da;
                    p_we = 1'b1; p_waddr = ha;
                    pos_next = AW'(lchild);
                    moved_next = 1'b1;
                    state_next = S_DN_RD;
                end
                else
                begin
                    state_next = S_FINAL;
                end
            end
            S_FINAL:
            begin
                // erase that did not move down: try sifting up
                if (mode_reg == MODE_ERASE && !moved_reg && !erase_up_reg)
                begin
                    erase_up_next = 1'b1;
                    state_next = S_UP_RD;
                end
                else
                begin
                    s_we = 1'b1;
                    p_we = 1'b1;
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            count_reg     <= '0;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            clr_reg   <= clr_next;
            // hold the result until taken, then drop
            if (state_reg == S_OUT && (!out_valid_reg || m_tready))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && s_tvalid)
        begin
            mode_reg <= s_tdata[1:0];
            hin_reg  <= s_tdata[11:2];
            kin_reg  <= s_tdata[43:12];
        end
        key_reg      <= key_next;
        hnd_reg      <= hnd_next;
        pos_reg      <= pos_next;
        moved_reg    <= moved_next;
        erase_up_reg <= erase_up_next;
        rh_reg       <= rh_next;
        rk_reg       <= rk_next;
        st_reg       <= st_next;
        // load the result register as the transaction is handed over
        if (state_reg == S_OUT && (!out_valid_reg || m_tready))
        begin
            res_reg <= {11'(count_reg), st_reg, rk_reg, rh_reg};
        end
    end

endmodule

>>> test/indexed_min_heap_queue_tb.sv
module indexed_min_heap_queue_tb
    import imhq_pkg::*;
();

    localparam int DEPTH       = 1024;
    localparam int LIMIT       = 1500000;
    localparam int RANDOM_OPS  = 365;
    localparam int TAIL_CYCLES = 40;

    // one queue operation as the sender offers it
    typedef struct packed {
        logic [1:0]  mode;
        logic [9:0]  handle;
        logic [31:0] key;
    } op_t;

    // one answer as the block returns it
    typedef struct packed {
        logic [9:0]  handle;
        logic [31:0] key;
        logic [1:0]  status;
        logic [10:0] total;
    } answer_t;

    // directed row: expectation given only where it is obvious
    typedef struct {
        op_t     op;
        bit      fixed;
        answer_t want;
    } row_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;   // mode[1:0], item_handle[11:2], item_key[43:12]
    logic        m_tvalid;
    logic        m_tready;
    logic [55:0] m_tdata;   // out_handle[9:0], out_key[41:10], status[43:42],
                            // entry_total[54:44]

    indexed_min_heap_queue u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // shadow heap: slots hold signed keys, handle_pos tracks each handle's slot
    logic signed [31:0] heap_key [DEPTH];
    logic [9:0]         heap_hdl [DEPTH];
    int                 handle_pos [DEPTH];
    bit                 held [DEPTH];
    int                 held_count;

    answer_t answers_due [$];
    row_t    rows [$];
    int      fail_count;
    int      cycle_count;
    bit      hold_off;

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] exp);
        $display("mismatch %s: got %0h expected %0h at cycle %0d", what, got, exp, cycle_count);
        fail_count++;
    endtask

    function automatic void add_row(input op_t op, input bit fixed, input answer_t want);
        row_t r;
        r.op    = op;
        r.fixed = fixed;
        r.want  = want;
        rows.insert(rows.size(), r);
    endfunction

    function automatic void heap_put(input int s, input logic signed [31:0] k,
                                     input logic [9:0] h);
        heap_key[s]   = k;
        heap_hdl[s]   = h;
        handle_pos[h] = s;
    endfunction

    function automatic bit heap_rise(input int s);
        logic signed [31:0] k;
        logic [9:0]         h;
        int                 p;
        bit                 moved;
        k     = heap_key[s];
        h     = heap_hdl[s];
        moved = 1'b0;
        while (s != 0)
        begin
            p = (s - 1) >> 1;
            if (!(k < heap_key[p]))
                break;
            heap_put(s, heap_key[p], heap_hdl[p]);
            s     = p;
            moved = 1'b1;
        end
        if (moved)
            heap_put(s, k, h);
        return moved;
    endfunction

    function automatic bit heap_sink(input int s);
        logic signed [31:0] k;
        logic [9:0]         h;
        int                 c;
        bit                 moved;
        k     = heap_key[s];
        h     = heap_hdl[s];
        moved = 1'b0;
        forever
        begin
            c = 2 * s + 1;
            if (c >= held_count)
                break;
            // left child wins ties
            if (c + 1 < held_count && heap_key[c + 1] < heap_key[c])
                c++;
            if (!(heap_key[c] < k))
                break;
            heap_put(s, heap_key[c], heap_hdl[c]);
            s     = c;
            moved = 1'b1;
        end
        if (moved)
            heap_put(s, k, h);
        return moved;
    endfunction

    // apply one operation to the shadow heap and return the answer it implies
    function automatic answer_t heap_apply(input op_t op);
        answer_t a;
        int      s;
        a = '0;
        case (op.mode)
            MODE_PUSH:
            begin
                if (held_count >= DEPTH)
                    a.status = ST_FULL;
                else if (held[op.handle])
                    a.status = ST_HANDLE;
                else
                begin
                    s = held_count;
                    held_count++;
                    heap_put(s, op.key, op.handle);
                    held[op.handle] = 1'b1;
                    void'(heap_rise(s));
                end
            end
            MODE_POP:
            begin
                if (held_count == 0)
                    a.status = ST_EMPTY;
                else
                begin
                    a.handle = heap_hdl[0];
                    a.key    = heap_key[0];
                    held[heap_hdl[0]] = 1'b0;
                    held_count--;
                    if (held_count > 0)
                    begin
                        heap_put(0, heap_key[held_count], heap_hdl[held_count]);
                        void'(heap_sink(0));
                    end
                end
            end
            MODE_ERASE:
            begin
                if (!held[op.handle])
                    a.status = ST_HANDLE;
                else
                begin
                    s = handle_pos[op.handle];
                    a.handle = op.handle;
                    a.key    = heap_key[s];
                    held[op.handle] = 1'b0;
                    held_count--;
                    // fill the hole from the last slot unless it is the hole
                    if (s != held_count)
                    begin
                        heap_put(s, heap_key[held_count], heap_hdl[held_count]);
                        if (!heap_sink(s))
                            void'(heap_rise(s));
                    end
                end
            end
            default: ;  // unused mode leaves the heap alone
        endcase
        a.total = held_count[10:0];
        return a;
    endfunction

    // offer one transaction after a random gap and wait for acceptance
    task automatic send_op(input op_t op);
        int gap;
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0, op.key, op.handle, op.mode};
        do @(posedge clk); while (!s_tready);
        answers_due.insert(answers_due.size(), heap_apply(op));
        @(negedge clk);
    endtask

    function automatic op_t rand_op(input int phase);
        op_t op;
        int  pick;
        op.handle = 10'($urandom_range(0, 1023));
        op.key    = $urandom;
        case ($urandom_range(0, 7))
            0: op.key = 32'sh8000_0000;
            1: op.key = 32'sh7fff_ffff;
            2: op.key = 32'($urandom_range(0, 15)) - 32'sd8;  // many ties
            default: ;
        endcase
        pick = $urandom_range(0, 99);
        // phase shapes the mix: grow, churn, drain
        if (pick < (phase == 0 ? 70 : phase == 1 ? 40 : 15))
            op.mode = MODE_PUSH;
        else if (pick < (phase == 2 ? 70 : 75))
            op.mode = MODE_POP;
        else if (pick < 98)
            op.mode = MODE_ERASE;
        else
            op.mode = MODE_NOP;
        // erase mostly targets a handle that is held
        if (op.mode == MODE_ERASE && held_count > 0 && $urandom_range(0, 4) != 0)
            op.handle = heap_hdl[$urandom_range(0, held_count - 1)];
        return op;
    endfunction

    // receiver: random stalls, plus one long hold-off requested by the sender
    initial
    begin
        int stall;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off)
            begin
                m_tready <= 1'b0;
                repeat (300) @(negedge clk);
                hold_off = 1'b0;
            end
            stall = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
            if ($urandom_range(0, 3) == 0)
                stall = 0;
            if (stall != 0)
            begin
                m_tready <= 1'b0;
                repeat (stall - 1) @(negedge clk);
                @(negedge clk);
            end
            m_tready <= 1'b1;
        end
    end

    // check every answer against the oldest prediction
    always @(posedge clk)
    begin
        answer_t got;
        answer_t exp;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.handle = m_tdata[9:0];
            got.key    = m_tdata[41:10];
            got.status = m_tdata[43:42];
            got.total  = m_tdata[54:44];
            if (answers_due.size() == 0)
            begin
                $display("unexpected answer %0h at cycle %0d", m_tdata, cycle_count);
                fail_count++;
            end
            else
            begin
                exp = answers_due.pop_front();
                if (got.handle !== exp.handle) report("out_handle", 32'(got.handle), 32'(exp.handle));
                if (got.key !== exp.key)       report("out_key", got.key, exp.key);
                if (got.status !== exp.status) report("status", 32'(got.status), 32'(exp.status));
                if (got.total !== exp.total)   report("entry_total", 32'(got.total), 32'(exp.total));
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        answer_t a;
        int      i;
        int      phase;
        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        fail_count = 0;
        cycle_count = 0;
        hold_off   = 1'b0;
        held_count = 0;
        for (i = 0; i < DEPTH; i++)
            held[i] = 1'b0;

        // directed rows; fixed expectations only where obvious
        a = '0; a.status = ST_EMPTY;
        add_row('{MODE_POP, 10'd0, 32'd0}, 1'b1, a);
        a = '0; a.status = ST_HANDLE;
        add_row('{MODE_ERASE, 10'd5, 32'd0}, 1'b1, a);
        a = '0; a.total = 11'd1;
        add_row('{MODE_PUSH, 10'd1023, 32'sh7fff_ffff}, 1'b1, a);
        a = '0; a.status = ST_HANDLE; a.total = 11'd1;
        add_row('{MODE_PUSH, 10'd1023, 32'd7}, 1'b1, a);
        a = '0; a.handle = 10'd1023; a.key = 32'h7fff_ffff;
        add_row('{MODE_POP, 10'd0, 32'd0}, 1'b1, a);  // only entry
        add_row('{MODE_PUSH, 10'd0, 32'sh8000_0000}, 1'b0, a);
        add_row('{MODE_PUSH, 10'd10, 32'sd5}, 1'b0, a);
        add_row('{MODE_PUSH, 10'd11, 32'sd5}, 1'b0, a);
        add_row('{MODE_PUSH, 10'd12, -32'sd1}, 1'b0, a);
        add_row('{MODE_PUSH, 10'd13, 32'sd5}, 1'b0, a);
        add_row('{MODE_PUSH, 10'h2aa, 32'sh7fff_ffff}, 1'b0, a);
        add_row('{MODE_PUSH, 10'h155, 32'h5555_5555}, 1'b0, a);
        add_row('{MODE_ERASE, 10'h155, 32'hffff_ffff}, 1'b0, a);  // last slot
        add_row('{MODE_ERASE, 10'd10, 32'd0}, 1'b0, a);
        add_row('{MODE_ERASE, 10'd0, 32'd0}, 1'b0, a);            // root
        add_row('{MODE_NOP, 10'h3ff, 32'hffff_ffff}, 1'b0, a);    // unused mode
        add_row('{MODE_POP, 10'h3ff, 32'd0}, 1'b0, a);
        add_row('{MODE_POP, 10'd0, 32'd0}, 1'b0, a);
        add_row('{MODE_POP, 10'd0, 32'd0}, 1'b0, a);
        add_row('{MODE_POP, 10'd0, 32'd0}, 1'b0, a);
        a = '0; a.status = ST_EMPTY;
        add_row('{MODE_POP, 10'd0, 32'd0}, 1'b1, a);

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (rows[r])
        begin
            send_op(rows[r].op);
            if (rows[r].fixed && answers_due[$] !== rows[r].want)
                report("directed row", 32'(r), 32'(rows[r].op.mode));
        end

        // fill the heap to capacity while the receiver holds off for a stretch
        hold_off = 1'b1;
        for (i = 0; i < DEPTH; i++)
            send_op('{MODE_PUSH, 10'(i), $urandom});
        send_op('{MODE_PUSH, 10'd3, 32'd0});   // full
        for (i = 0; i < 40; i++)
            send_op('{MODE_POP, 10'd0, 32'd0});

        for (i = 0; i < RANDOM_OPS; i++)
        begin
            phase = (i / 120) % 3;
            send_op(rand_op(phase));
        end
        s_tvalid <= 1'b0;

        while (answers_due.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

>>> files.f
hdl/imhq_pkg.sv
hdl/imhq_slot_ram.sv
hdl/imhq_pos_ram.sv
hdl/indexed_min_heap_queue.sv
test/indexed_min_heap_queue_tb.sv
